[design/mexp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared action codes, decoded operation type and port widths for the
// monomial exponent ALU.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int ACTION_W    = 3;
    localparam int DATA_W      = 64;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TUSER_W = 2;
    localparam int FLAG_BIT    = 0;
    localparam int ERROR_BIT   = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_MUL  = 3'd0,
        ACT_DIV  = 3'd1,
        ACT_EQ   = 3'd2,
        ACT_LEX  = 3'd3,
        ACT_GLEX = 3'd4
    } action_t;

    // one-hot decode of the action; all zero for an undefined code
    typedef struct packed {
        logic mul;
        logic div;
        logic eq;
        logic lex;
        logic glex;
    } op_t;

endpackage

[design/mexp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_lane
// Stage 1: action decode, per-lane add, subtract and compare, and the total
// degree of both monomials.
// ----------------------------------------------------------------------------
module mexp_lane #(
    parameter int NUM_VARS = 8,
    parameter int EXP_BITS = 8,
    localparam int LANE_W  = NUM_VARS * EXP_BITS,
    localparam int EXT_W   = (LANE_W > mexp_pkg::DATA_W) ? LANE_W : mexp_pkg::DATA_W,
    localparam int SUM_W   = NUM_VARS * (EXP_BITS + 1),
    localparam int DEG_W   = EXP_BITS + $clog2(NUM_VARS)
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [mexp_pkg::ACTION_W-1:0] action,
    input  logic [mexp_pkg::DATA_W-1:0]   exponents_a,
    input  logic [mexp_pkg::DATA_W-1:0]   exponents_b,
    output mexp_pkg::op_t                 op,
    output logic [SUM_W-1:0]              sum,
    output logic [LANE_W-1:0]             diff,
    output logic [NUM_VARS-1:0]           lt,
    output logic [NUM_VARS-1:0]           gt,
    output logic [DEG_W-1:0]              deg_a,
    output logic [DEG_W-1:0]              deg_b
);

    mexp_pkg::op_t          op_reg,    op_next;
    logic [SUM_W-1:0]       sum_reg,   sum_next;
    logic [LANE_W-1:0]      diff_reg,  diff_next;
    logic [NUM_VARS-1:0]    lt_reg,    lt_next;
    logic [NUM_VARS-1:0]    gt_reg,    gt_next;
    logic [DEG_W-1:0]       deg_a_reg, deg_a_next;
    logic [DEG_W-1:0]       deg_b_reg, deg_b_next;
    logic [EXT_W-1:0]       a_x;
    logic [EXT_W-1:0]       b_x;

    // lanes past bit 63 read as zero
    assign a_x = EXT_W'(exponents_a);
    assign b_x = EXT_W'(exponents_b);

    always_comb
    begin
        op_next = '0;
        unique case (mexp_pkg::action_t'(action))
            mexp_pkg::ACT_MUL:  op_next.mul  = 1'b1;
            mexp_pkg::ACT_DIV:  op_next.div  = 1'b1;
            mexp_pkg::ACT_EQ:   op_next.eq   = 1'b1;
            mexp_pkg::ACT_LEX:  op_next.lex  = 1'b1;
            mexp_pkg::ACT_GLEX: op_next.glex = 1'b1;
            default:            op_next      = '0;
        endcase
    end

    always_comb
    begin
        logic [EXP_BITS-1:0] la;
        logic [EXP_BITS-1:0] lb;
        sum_next   = '0;
        diff_next  = '0;
        lt_next    = '0;
        gt_next    = '0;
        deg_a_next = '0;
        deg_b_next = '0;
        for (int i = 0; i < NUM_VARS; i++)
        begin
            la = a_x[i*EXP_BITS +: EXP_BITS];
            lb = b_x[i*EXP_BITS +: EXP_BITS];
            sum_next[i*(EXP_BITS+1) +: EXP_BITS+1] = {1'b0, la} + {1'b0, lb};
            diff_next[i*EXP_BITS +: EXP_BITS]      = la - lb;
            lt_next[i]  = (la < lb);
            gt_next[i]  = (la > lb);
            deg_a_next  = deg_a_next + DEG_W'(la);
            deg_b_next  = deg_b_next + DEG_W'(lb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= op_next;
            sum_reg   <= sum_next;
            diff_reg  <= diff_next;
            lt_reg    <= lt_next;
            gt_reg    <= gt_next;
            deg_a_reg <= deg_a_next;
            deg_b_reg <= deg_b_next;
        end
    end

    assign op    = op_reg;
    assign sum   = sum_reg;
    assign diff  = diff_reg;
    assign lt    = lt_reg;
    assign gt    = gt_reg;
    assign deg_a = deg_a_reg;
    assign deg_b = deg_b_reg;

endmodule

[design/mexp_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_reduce
// Stage 2: lane saturation, divide check, equality, lexicographic search
// from the top lane down, and degree compare.
// ----------------------------------------------------------------------------
module mexp_reduce #(
    parameter int NUM_VARS = 8,
    parameter int EXP_BITS = 8,
    localparam int LANE_W  = NUM_VARS * EXP_BITS,
    localparam int SUM_W   = NUM_VARS * (EXP_BITS + 1),
    localparam int DEG_W   = EXP_BITS + $clog2(NUM_VARS)
) (
    input  logic                clk,
    input  logic                load,
    input  mexp_pkg::op_t       op_in,
    input  logic [SUM_W-1:0]    sum,
    input  logic [LANE_W-1:0]   diff,
    input  logic [NUM_VARS-1:0] lt,
    input  logic [NUM_VARS-1:0] gt,
    input  logic [DEG_W-1:0]    deg_a,
    input  logic [DEG_W-1:0]    deg_b,
    output mexp_pkg::op_t       op,
    output logic [LANE_W-1:0]   mul_res,
    output logic                mul_err,
    output logic [LANE_W-1:0]   div_res,
    output logic                div_err,
    output logic                eq,
    output logic                lex,
    output logic                deg_lt,
    output logic                deg_eq
);

    mexp_pkg::op_t        op_reg;
    logic [LANE_W-1:0]    mul_res_reg, mul_res_next;
    logic                 mul_err_reg, mul_err_next;
    logic [LANE_W-1:0]    div_res_reg;
    logic                 div_err_reg;
    logic                 eq_reg,      eq_next;
    logic                 lex_reg,     lex_next;
    logic                 deg_lt_reg;
    logic                 deg_eq_reg;
    logic [NUM_VARS-1:0]  neq;

    assign neq = lt | gt;

    always_comb
    begin
        logic [EXP_BITS:0] s;
        mul_res_next = '0;
        mul_err_next = 1'b0;
        for (int i = 0; i < NUM_VARS; i++)
        begin
            s = sum[i*(EXP_BITS+1) +: EXP_BITS+1];
            mul_res_next[i*EXP_BITS +: EXP_BITS] = s[EXP_BITS] ? {EXP_BITS{1'b1}}
                                                               : s[EXP_BITS-1:0];
            mul_err_next = mul_err_next | s[EXP_BITS];
        end
    end

    // a < b decided by the highest lane that differs
    always_comb
    begin
        lex_next = 1'b0;
        for (int i = 0; i < NUM_VARS; i++)
        begin
            lex_next = lex_next | (lt[i] & ~|(neq >> (i + 1)));
        end
        eq_next = ~|neq;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg      <= op_in;
            mul_res_reg <= mul_res_next;
            mul_err_reg <= mul_err_next;
            div_res_reg <= diff;
            div_err_reg <= |lt;
            eq_reg      <= eq_next;
            lex_reg     <= lex_next;
            deg_lt_reg  <= (deg_a < deg_b);
            deg_eq_reg  <= (deg_a == deg_b);
        end
    end

    assign op      = op_reg;
    assign mul_res = mul_res_reg;
    assign mul_err = mul_err_reg;
    assign div_res = div_res_reg;
    assign div_err = div_err_reg;
    assign eq      = eq_reg;
    assign lex     = lex_reg;
    assign deg_lt  = deg_lt_reg;
    assign deg_eq  = deg_eq_reg;

endmodule

[design/mexp_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_select
// Stage 3: picks result, flag and error by action into the output register.
// ----------------------------------------------------------------------------
module mexp_select #(
    parameter int NUM_VARS = 8,
    parameter int EXP_BITS = 8,
    localparam int LANE_W  = NUM_VARS * EXP_BITS,
    localparam int EXT_W   = (LANE_W > mexp_pkg::DATA_W) ? LANE_W : mexp_pkg::DATA_W
) (
    input  logic                        clk,
    input  logic                        load,
    input  mexp_pkg::op_t               op,
    input  logic [LANE_W-1:0]           mul_res,
    input  logic                        mul_err,
    input  logic [LANE_W-1:0]           div_res,
    input  logic                        div_err,
    input  logic                        eq,
    input  logic                        lex,
    input  logic                        deg_lt,
    input  logic                        deg_eq,
    output logic [mexp_pkg::DATA_W-1:0] exponents_result,
    output logic                        flag,
    output logic                        error
);

    logic [mexp_pkg::DATA_W-1:0] result_reg, result_next;
    logic                        flag_reg,   flag_next;
    logic                        error_reg,  error_next;
    logic [LANE_W-1:0]           res_lane;
    logic [EXT_W-1:0]            res_x;

    always_comb
    begin
        priority if (op.mul)
            res_lane = mul_res;
        else if (op.div && !div_err)
            res_lane = div_res;
        else
            res_lane = '0;
    end

    // bits above 63 are dropped
    assign res_x       = EXT_W'(res_lane);
    assign result_next = res_x[mexp_pkg::DATA_W-1:0];

    always_comb
    begin
        priority if (op.eq)
            flag_next = eq;
        else if (op.lex)
            flag_next = lex;
        else if (op.glex)
            flag_next = deg_lt | (deg_eq & lex);
        else
            flag_next = 1'b0;
    end

    assign error_next = (op.mul & mul_err) | (op.div & div_err);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
            flag_reg   <= flag_next;
            error_reg  <= error_next;
        end
    end

    assign exponents_result = result_reg;
    assign flag             = flag_reg;
    assign error            = error_reg;

endmodule

[design/monomial_exponent_alu.sv]
`timescale 1ns / 1ps
// An accepted input item reaches m_tvalid after passing all three register stages.
// Throughput: one item per cycle while m_tready is high; three register stages (lane ops, reduce,
// output select), each advancing when the stage after it is empty or moving.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// monomial_exponent_alu
// Multiply, exact divide, equality and (graded) lexicographic compare of two
// packed exponent vectors, as a three-stage pipeline on stream channels.
// ----------------------------------------------------------------------------
module monomial_exponent_alu #(
    parameter int NUM_VARS = 8,   // 1 .. 16
    parameter int EXP_BITS = 8    // 2 .. 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mexp_pkg::IN_TDATA_W-1:0]  s_tdata,   // exponents_a[63:0], exponents_b[127:64]
    input  logic [mexp_pkg::ACTION_W-1:0]    s_tuser,   // action[2:0]
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mexp_pkg::DATA_W-1:0]      m_tdata,   // exponents_result[63:0]
    output logic [mexp_pkg::OUT_TUSER_W-1:0] m_tuser    // flag[0], error[1]
);

    localparam int LANE_W = NUM_VARS * EXP_BITS;
    localparam int SUM_W  = NUM_VARS * (EXP_BITS + 1);
    localparam int DEG_W  = EXP_BITS + $clog2(NUM_VARS);

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes new contents when it is empty or
    // the stage after it takes its item this cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ready1, ready2, ready3;
    logic load1, load2, load3;

    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign load1 = s_tvalid && ready1;
    assign load2 = v1_reg && ready2;
    assign load3 = v2_reg && ready3;

    assign v1_next = ready1 ? s_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s_tready = ready1;
    assign m_tvalid = v3_reg;

    // ------------------------------------------------------------------
    // Stage 1: decode, lane add/subtract/compare, total degrees
    // ------------------------------------------------------------------
    mexp_pkg::op_t       s1_op;
    logic [SUM_W-1:0]    s1_sum;
    logic [LANE_W-1:0]   s1_diff;
    logic [NUM_VARS-1:0] s1_lt;
    logic [NUM_VARS-1:0] s1_gt;
    logic [DEG_W-1:0]    s1_deg_a;
    logic [DEG_W-1:0]    s1_deg_b;

    mexp_lane #(
        .NUM_VARS (NUM_VARS),
        .EXP_BITS (EXP_BITS)
    ) u_lane (
        .clk         (clk),
        .load        (load1),
        .action      (s_tuser),
        .exponents_a (s_tdata[mexp_pkg::DATA_W-1:0]),
        .exponents_b (s_tdata[mexp_pkg::IN_TDATA_W-1:mexp_pkg::DATA_W]),
        .op          (s1_op),
        .sum         (s1_sum),
        .diff        (s1_diff),
        .lt          (s1_lt),
        .gt          (s1_gt),
        .deg_a       (s1_deg_a),
        .deg_b       (s1_deg_b)
    );

    // ------------------------------------------------------------------
    // Stage 2: saturation, divide check, lex search, degree compare
    // ------------------------------------------------------------------
    mexp_pkg::op_t     s2_op;
    logic [LANE_W-1:0] s2_mul_res;
    logic              s2_mul_err;
    logic [LANE_W-1:0] s2_div_res;
    logic              s2_div_err;
    logic              s2_eq;
    logic              s2_lex;
    logic              s2_deg_lt;
    logic              s2_deg_eq;

    mexp_reduce #(
        .NUM_VARS (NUM_VARS),
        .EXP_BITS (EXP_BITS)
    ) u_reduce (
        .clk     (clk),
        .load    (load2),
        .op_in   (s1_op),
        .sum     (s1_sum),
        .diff    (s1_diff),
        .lt      (s1_lt),
        .gt      (s1_gt),
        .deg_a   (s1_deg_a),
        .deg_b   (s1_deg_b),
        .op      (s2_op),
        .mul_res (s2_mul_res),
        .mul_err (s2_mul_err),
        .div_res (s2_div_res),
        .div_err (s2_div_err),
        .eq      (s2_eq),
        .lex     (s2_lex),
        .deg_lt  (s2_deg_lt),
        .deg_eq  (s2_deg_eq)
    );

    // ------------------------------------------------------------------
    // Stage 3: output register; holds its item while m_tready is low
    // ------------------------------------------------------------------
    logic out_flag;
    logic out_error;

    mexp_select #(
        .NUM_VARS (NUM_VARS),
        .EXP_BITS (EXP_BITS)
    ) u_select (
        .clk              (clk),
        .load             (load3),
        .op               (s2_op),
        .mul_res          (s2_mul_res),
        .mul_err          (s2_mul_err),
        .div_res          (s2_div_res),
        .div_err          (s2_div_err),
        .eq               (s2_eq),
        .lex              (s2_lex),
        .deg_lt           (s2_deg_lt),
        .deg_eq           (s2_deg_eq),
        .exponents_result (m_tdata),
        .flag             (out_flag),
        .error            (out_error)
    );

    assign m_tuser[mexp_pkg::FLAG_BIT]  = out_flag;
    assign m_tuser[mexp_pkg::ERROR_BIT] = out_error;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // flag belongs to compares, error to multiply/divide: never both
    a_flag_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_flag && out_error))
        else $error("flag and error both set on one item");

    // an accepted item always lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item lost at stage 1");

    // a stalled stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |=> v1_reg)
        else $error("stage 1 item dropped under stall");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> v2_reg)
        else $error("stage 2 item dropped under stall");

endmodule
